### rtl/core/tkd_pkg.sv
// Shared types, constants and hash round functions for the triple-key dedup table.
`timescale 1ns / 1ps
`default_nettype none

package tkd_pkg;

  // Default table depth, fixed field widths and hash sequencing constants.
  localparam int unsigned CapacityDef = 4096;
  localparam int unsigned CfgW        = 13;
  localparam int unsigned KeyW        = 32;
  localparam int unsigned IdxW        = 12;
  localparam int unsigned OpW         = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned HashRounds  = 3;
  localparam int unsigned ModBitsPerCycle = 4;
  localparam int unsigned ModCycles   = KeyW / ModBitsPerCycle;

  // Operation codes; the unused code behaves as a lookup.
  typedef enum logic [OpW-1:0] {
    OP_LOOKUP     = 2'd0,
    OP_INSERT     = 2'd1,
    OP_LOOKUP_INS = 2'd2
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // One request word as held inside the block.
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [KeyW-1:0] key_a;
    logic [KeyW-1:0] key_b;
    logic [KeyW-1:0] key_c;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [IdxW-1:0]    entry_index;
    logic               found;
    logic [StatusW-1:0] status;
  } res_t;

  // One table slot.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key_a;
    logic [KeyW-1:0] key_b;
    logic [KeyW-1:0] key_c;
    logic [IdxW-1:0] index;
  } entry_t;

  // Fixed round key, byte k at bits [8k+7:8k].
  localparam logic [127:0] RoundKey = 128'h7b580009_07976b38_c15b857b_f4f86a0b;

  // Inverse substitution table.
  localparam logic [7:0] InvSbox [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // Multiply by two in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // One inverse round: shift rows, substitute, mix columns, add key.
  function automatic logic [127:0] inv_round(input logic [127:0] st);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0]   s0, s1, s2, s3;
    logic [7:0]   x2 [4];
    logic [7:0]   x4 [4];
    logic [7:0]   x8 [4];
    logic [7:0]   s  [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[8*(4*c+r) +: 8] = InvSbox[st[8*(4*((c-r)&3)+r) +: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      s0 = t[8*(4*c)   +: 8];
      s1 = t[8*(4*c+1) +: 8];
      s2 = t[8*(4*c+2) +: 8];
      s3 = t[8*(4*c+3) +: 8];
      s[0] = s0; s[1] = s1; s[2] = s2; s[3] = s3;
      for (int k = 0; k < 4; k++) begin
        x2[k] = xt(s[k]);
        x4[k] = xt(x2[k]);
        x8[k] = xt(x4[k]);
      end
      // 14 = 8+4+2, 11 = 8+2+1, 13 = 8+4+1, 9 = 8+1.
      m[8*(4*c) +: 8]   = (x8[0]^x4[0]^x2[0]) ^ (x8[1]^x2[1]^s[1]) ^
                          (x8[2]^x4[2]^s[2]) ^ (x8[3]^s[3]);
      m[8*(4*c+1) +: 8] = (x8[0]^s[0]) ^ (x8[1]^x4[1]^x2[1]) ^
                          (x8[2]^x2[2]^s[2]) ^ (x8[3]^x4[3]^s[3]);
      m[8*(4*c+2) +: 8] = (x8[0]^x4[0]^s[0]) ^ (x8[1]^s[1]) ^
                          (x8[2]^x4[2]^x2[2]) ^ (x8[3]^x2[3]^s[3]);
      m[8*(4*c+3) +: 8] = (x8[0]^x2[0]^s[0]) ^ (x8[1]^x4[1]^s[1]) ^
                          (x8[2]^s[2]) ^ (x8[3]^x4[3]^x2[3]);
    end
    return m ^ RoundKey;
  endfunction

endpackage

`default_nettype wire

### rtl/core/tkd_hash.sv
// Key hash unit: three inverse cipher rounds, then a remainder by the table size.
`timescale 1ns / 1ps
`default_nettype none

module tkd_hash #(
  parameter int unsigned CAPACITY = tkd_pkg::CapacityDef,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned SW = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [tkd_pkg::KeyW-1:0]  key_a_i,
  input  wire logic [tkd_pkg::KeyW-1:0]  key_b_i,
  input  wire logic [tkd_pkg::KeyW-1:0]  key_c_i,
  input  wire logic [SW-1:0]             size_i,
  output logic                           idle_o,
  output logic                           done_o,
  output logic [AW-1:0]                  slot_o
);

  typedef enum logic [2:0] {
    H_IDLE  = 3'b001,
    H_ROUND = 3'b010,
    H_MOD   = 3'b100
  } hstate_e;

  localparam int unsigned RW = $clog2(tkd_pkg::HashRounds);
  localparam int unsigned CW = $clog2(tkd_pkg::ModCycles);

  hstate_e                    state_q, state_d;
  logic [RW-1:0]              rnd_q, rnd_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [127:0]               st_q, st_d;
  logic [tkd_pkg::KeyW-1:0]   div_q, div_d;
  logic [SW-1:0]              rem_q, rem_d;
  logic                       done_q, done_d;
  logic [127:0]               round_out;
  logic [SW-1:0]              rem_step;
  logic [SW:0]                trial;

  // One round of the cipher on the held state.
  assign round_out = tkd_pkg::inv_round(st_q);

  // Restoring remainder over ModBitsPerCycle dividend bits, most significant first.
  always_comb begin
    rem_step = rem_q;
    trial    = '0;
    for (int k = 0; k < tkd_pkg::ModBitsPerCycle; k++) begin
      trial = {rem_step, div_q[tkd_pkg::KeyW-1-k]};
      if (trial >= {1'b0, size_i}) begin
        trial = trial - {1'b0, size_i};
      end
      rem_step = trial[SW-1:0];
    end
  end

  // Sequencer for rounds and remainder steps.
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    cnt_d   = cnt_q;
    st_d    = st_q;
    div_d   = div_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) begin
          st_d    = {key_a_i, key_b_i, key_c_i, 32'h0};
          rnd_d   = '0;
          state_d = H_ROUND;
        end
      end
      H_ROUND: begin
        st_d  = round_out;
        rnd_d = rnd_q + 1'b1;
        if (rnd_q == RW'(tkd_pkg::HashRounds - 1)) begin
          div_d   = round_out[tkd_pkg::KeyW-1:0];
          rem_d   = '0;
          cnt_d   = '0;
          state_d = H_MOD;
        end
      end
      H_MOD: begin
        rem_d = rem_step;
        div_d = div_q << tkd_pkg::ModBitsPerCycle;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(tkd_pkg::ModCycles - 1)) begin
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    cnt_q <= cnt_d;
    st_q  <= st_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign idle_o = (state_q == H_IDLE) && !done_q;
  assign done_o = done_q;
  assign slot_o = AW'(rem_q);

endmodule

`default_nettype wire

### rtl/core/tkd_probe.sv
// Slot memory with the clearing pass and the linear probe sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tkd_probe #(
  parameter int unsigned CAPACITY = tkd_pkg::CapacityDef,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned SW = $clog2(CAPACITY + 1)
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [AW-1:0]  slot_i,
  input  wire logic [SW-1:0]  size_i,
  input  wire tkd_pkg::item_t item_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output tkd_pkg::res_t       res_o,
  input  wire logic           res_ready_i
);

  typedef enum logic [3:0] {
    P_CLEAR = 4'b0001,
    P_IDLE  = 4'b0010,
    P_CHECK = 4'b0100,
    P_RESP  = 4'b1000
  } pstate_e;

  pstate_e                   state_q, state_d;
  logic [AW-1:0]             clr_q, clr_d;
  logic [AW-1:0]             slot_q, slot_d;
  logic [SW-1:0]             cnt_q, cnt_d;
  logic [tkd_pkg::IdxW-1:0]  nxt_q, nxt_d;
  tkd_pkg::res_t             res_q, res_d;

  tkd_pkg::entry_t           mem [CAPACITY];
  tkd_pkg::entry_t           rd_q;
  tkd_pkg::entry_t           wr_data;
  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;

  logic [SW-1:0]             slot_inc;
  logic [AW-1:0]             slot_nxt;
  logic                      is_ins, key_eq, last_probe;

  // Probe address walk with wrap at the table size.
  assign slot_inc   = SW'(slot_q) + 1'b1;
  assign slot_nxt   = (slot_inc == size_i) ? '0 : AW'(slot_inc);
  assign is_ins     = (item_i.op == tkd_pkg::OP_INSERT) ||
                      (item_i.op == tkd_pkg::OP_LOOKUP_INS);
  assign key_eq     = (rd_q.key_a == item_i.key_a) && (rd_q.key_b == item_i.key_b) &&
                      (rd_q.key_c == item_i.key_c);
  assign last_probe = (cnt_q + 1'b1) == size_i;

  // Probe sequencer. Apart from the clearing pass, writes happen only at the end
  // of an item, so a read of the same slot by the next item always comes later.
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    slot_d  = slot_q;
    cnt_d   = cnt_q;
    nxt_d   = nxt_q;
    res_d   = res_q;
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = slot_nxt;
    unique case (state_q)
      P_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == AW'(CAPACITY - 1)) begin
          state_d = P_IDLE;
        end
      end
      P_IDLE: begin
        rd_addr = slot_i;
        if (start_i) begin
          rd_en   = 1'b1;
          slot_d  = slot_i;
          cnt_d   = '0;
          state_d = P_CHECK;
        end
      end
      P_CHECK: begin
        res_d = '0;
        if (!rd_q.valid) begin
          if (is_ins) begin
            wr_en         = 1'b1;
            wr_data       = {1'b1, item_i.key_a, item_i.key_b, item_i.key_c, nxt_q};
            res_d.entry_index = nxt_q;
            res_d.status  = tkd_pkg::ST_OK;
            nxt_d         = nxt_q + 1'b1;
          end else begin
            res_d.status  = tkd_pkg::ST_MISS;
          end
          state_d = P_RESP;
        end else if (item_i.op != tkd_pkg::OP_INSERT && key_eq) begin
          res_d.entry_index = rd_q.index;
          res_d.found       = 1'b1;
          res_d.status      = tkd_pkg::ST_OK;
          state_d           = P_RESP;
        end else if (last_probe) begin
          res_d.status = is_ins ? tkd_pkg::ST_FULL : tkd_pkg::ST_MISS;
          state_d      = P_RESP;
        end else begin
          rd_en  = 1'b1;
          slot_d = slot_nxt;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      P_RESP: begin
        if (res_ready_i) begin
          state_d = P_IDLE;
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  // Slot memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_CLEAR;
      clr_q   <= '0;
      nxt_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nxt_q   <= nxt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
  end

  assign idle_o      = (state_q == P_IDLE);
  assign res_valid_o = (state_q == P_RESP);
  assign res_o       = res_q;

endmodule

`default_nettype wire

### rtl/core/triple_key_dedup_hash_table.sv
// Top level of the triple-key dedup hash table: handshakes, size register, output word.
//
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid/s_axis_tready        op, key_a, key_b, key_c
// m_axis    out  m_axis_tvalid/m_axis_tready        entry_index, found, status
// cfg       in   cfg_we_i                         table_size
//
// One word is in work at a time: the cipher rounds, the remainder steps, then
// a linear probe of 1..size slots from the home slot; the next word is taken
// once the result has moved into the output register.
// After reset a clearing pass writes every slot with s_axis_tready low. A
// finished word waits in the output register, so the next word is taken
// while the result is stalled.
`timescale 1ns / 1ps
`default_nettype none

module triple_key_dedup_hash_table #(
  parameter int unsigned CAPACITY = tkd_pkg::CapacityDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // op [1:0], key_a [33:2], key_b [65:34], key_c [97:66], zero fill above
  input  wire logic [103:0]               s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // entry_index [11:0], found [12], status [14:13], zero fill [15]
  output logic [15:0]                     m_axis_tdata,
  input  wire logic                       cfg_we_i,
  input  wire logic [tkd_pkg::CfgW-1:0]   cfg_wdata_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned SW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (SW > tkd_pkg::CfgW) ? SW : tkd_pkg::CfgW;

  logic [tkd_pkg::CfgW-1:0] size_cfg_q;
  logic [CW-1:0]            size_wide;
  logic [SW-1:0]            size_eff;
  logic                     busy_q, busy_d;
  logic                     out_valid_q, out_valid_d;
  tkd_pkg::res_t            out_q;
  tkd_pkg::item_t           item_q, in_item;
  logic                     in_acc, hash_idle, hash_done, probe_idle;
  logic                     res_valid, res_take;
  logic [AW-1:0]            hash_slot;
  tkd_pkg::res_t            probe_res;

  // Table size register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_cfg_q <= tkd_pkg::CfgW'(4096);
    end else if (cfg_we_i) begin
      size_cfg_q <= cfg_wdata_i;
    end
  end

  // Effective size: zero acts as one, anything above the depth as the depth.
  always_comb begin
    size_wide = CW'(size_cfg_q);
    if (size_wide == '0) begin
      size_wide = CW'(1);
    end else if (size_wide > CW'(CAPACITY)) begin
      size_wide = CW'(CAPACITY);
    end
    size_eff = size_wide[SW-1:0];
  end

  // Input unpacking and acceptance.
  assign in_item.op    = s_axis_tdata[1:0];
  assign in_item.key_a = s_axis_tdata[33:2];
  assign in_item.key_b = s_axis_tdata[65:34];
  assign in_item.key_c = s_axis_tdata[97:66];

  assign s_axis_tready = !busy_q && hash_idle && probe_idle;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
    end
  end

  tkd_hash #(
    .CAPACITY (CAPACITY)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .key_a_i (in_item.key_a),
    .key_b_i (in_item.key_b),
    .key_c_i (in_item.key_c),
    .size_i  (size_eff),
    .idle_o  (hash_idle),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  tkd_probe #(
    .CAPACITY (CAPACITY)
  ) u_probe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (hash_done),
    .slot_i      (hash_slot),
    .size_i      (size_eff),
    .item_i      (item_q),
    .idle_o      (probe_idle),
    .res_valid_o (res_valid),
    .res_o       (probe_res),
    .res_ready_i (res_take)
  );

  // Output register and busy tracking.
  assign res_take = res_valid && (!out_valid_q || m_axis_tready);

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
      busy_d      = 1'b0;
    end
    if (in_acc) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= probe_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.status, out_q.found, out_q.entry_index};

`ifndef SYNTHESIS
  // The hash only finishes when the probe unit can take the slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) hash_done |-> probe_idle)
    else $error("hash finished while probe unit busy");

  // A full table never reports an index or a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == tkd_pkg::ST_FULL) |->
      (out_q.entry_index == '0 && !out_q.found))
    else $error("full status with index or hit");

  // A hit always reports success.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.found) |-> (out_q.status == tkd_pkg::ST_OK))
    else $error("hit without ok status");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the triple-key dedup hash table, with a scoreboard class.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Slots = 4096;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // op [1:0], key_a [33:2], key_b [65:34], key_c [97:66], zero fill above
  logic [103:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // entry_index [11:0], found [12], status [14:13], zero fill [15]
  logic [15:0]  m_axis_tdata;
  logic         cfg_we_i;
  logic [12:0]  cfg_wdata_i;

  bit steady;
  bit hold_done;
  int hold_left;

  // Mirror of the table contents; predicts one result word per request word.
  class dedup_scoreboard;
    bit            slot_used [Slots];
    logic [31:0]   slot_a [Slots];
    logic [31:0]   slot_b [Slots];
    logic [31:0]   slot_c [Slots];
    logic [11:0]   slot_idx [Slots];
    logic [12:0]   next_idx;
    logic [12:0]   size_reg;
    logic [7:0]    inv_sub [256];
    tkd_pkg::res_t pending_results [$];
    int            errors;
    int            checked;

    function new();
      logic [7:0] b, r, p;
      int e;
      for (int s = 0; s < 256; s++) begin
        b = rol(s, 1) ^ rol(s, 3) ^ rol(s, 6) ^ 8'h05;
        r = 8'h01;
        p = b;
        e = 254;
        while (e != 0) begin
          if (e & 1) r = gmul(r, p);
          p = gmul(p, p);
          e = e >> 1;
        end
        inv_sub[s] = (b == 0) ? 8'h00 : r;
      end
      next_idx = '0;
      size_reg = 13'd4096;
      errors = 0;
      checked = 0;
    endfunction

    function logic [7:0] rol(logic [7:0] x, int n);
      return (x << n) | (x >> (8 - n));
    endfunction

    function logic [7:0] gmul(logic [7:0] x, logic [7:0] y);
      logic [7:0] acc;
      acc = 0;
      for (int i = 0; i < 8; i++) begin
        if (y[0]) acc ^= x;
        x = x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
        y = y >> 1;
      end
      return acc;
    endfunction

    // Three inverse cipher rounds over {a, b, c, 0}; byte k sits at bits [8k+7:8k].
    function logic [31:0] home_hash(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic [127:0] rkey;
      logic [7:0] st [16];
      logic [7:0] t [16];
      logic [127:0] v;
      rkey = 128'h7b580009_07976b38_c15b857b_f4f86a0b;
      v = {a, b, c, 32'h0};
      for (int k = 0; k < 16; k++) st[k] = v[8*k +: 8];
      for (int rnd = 0; rnd < 3; rnd++) begin
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++)
            t[4*col+row] = inv_sub[st[4*((col-row)&3)+row]];
        for (int col = 0; col < 4; col++) begin
          st[4*col]   = gmul(t[4*col], 14) ^ gmul(t[4*col+1], 11) ^
                        gmul(t[4*col+2], 13) ^ gmul(t[4*col+3], 9);
          st[4*col+1] = gmul(t[4*col], 9) ^ gmul(t[4*col+1], 14) ^
                        gmul(t[4*col+2], 11) ^ gmul(t[4*col+3], 13);
          st[4*col+2] = gmul(t[4*col], 13) ^ gmul(t[4*col+1], 9) ^
                        gmul(t[4*col+2], 14) ^ gmul(t[4*col+3], 11);
          st[4*col+3] = gmul(t[4*col], 11) ^ gmul(t[4*col+1], 13) ^
                        gmul(t[4*col+2], 9) ^ gmul(t[4*col+3], 14);
        end
        for (int k = 0; k < 16; k++) st[k] ^= rkey[8*k +: 8];
      end
      return {st[3], st[2], st[1], st[0]};
    endfunction

    // Notes an accepted request word and queues the result it must produce.
    function void note(logic [1:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
      int unsigned size, slot, empty_slot;
      bit have_empty, hit;
      tkd_pkg::res_t r;
      size = size_reg;
      if (size == 0) size = 1;
      if (size > Slots) size = Slots;
      slot = home_hash(a, b, c) % size;
      have_empty = 0;
      hit = 0;
      empty_slot = 0;
      r = '0;
      for (int unsigned i = 0; i < size; i++) begin
        if (!slot_used[slot]) begin
          have_empty = 1;
          empty_slot = slot;
          break;
        end
        if (op != tkd_pkg::OP_INSERT && slot_a[slot] == a && slot_b[slot] == b &&
            slot_c[slot] == c) begin
          hit = 1;
          r.entry_index = slot_idx[slot];
          break;
        end
        slot = (slot + 1 >= size) ? 0 : slot + 1;
      end
      if (hit) begin
        r.found = 1'b1;
        r.status = tkd_pkg::ST_OK;
      end else if (op == tkd_pkg::OP_INSERT || op == tkd_pkg::OP_LOOKUP_INS) begin
        if (have_empty) begin
          slot_used[empty_slot] = 1;
          slot_a[empty_slot] = a;
          slot_b[empty_slot] = b;
          slot_c[empty_slot] = c;
          slot_idx[empty_slot] = next_idx[11:0];
          r.entry_index = next_idx[11:0];
          next_idx = next_idx + 1;
          r.status = tkd_pkg::ST_OK;
        end else begin
          r.status = tkd_pkg::ST_FULL;
        end
      end else begin
        r.status = tkd_pkg::ST_MISS;
      end
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compares one accepted result word with the oldest expectation.
    task check(logic [15:0] word);
      tkd_pkg::res_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result %h", word));
        return;
      end
      want = pending_results.pop_front();
      if (word[11:0] !== want.entry_index)
        report($sformatf("entry_index %0d, want %0d", word[11:0], want.entry_index));
      if (word[12] !== want.found)
        report($sformatf("found %b, want %b", word[12], want.found));
      if (word[14:13] !== want.status)
        report($sformatf("status %0d, want %0d", word[14:13], want.status));
    endtask
  endclass

  dedup_scoreboard sb;
  logic [31:0] key_pool [48][3];

  triple_key_dedup_hash_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Safety limit on the whole run.
  initial begin
    #60ms;
    $display("[triple_key_dedup_hash_table] ERROR");
    $finish;
  end

  // Offers one request word and waits until it is taken.
  task send_word(logic [1:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c);
    if (!steady && $urandom_range(99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, c, b, a, op};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(op, a, b, c);
  endtask

  // Writes the size register once all outstanding results are back.
  task write_size(logic [12:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.size_reg = value;
  endtask

  // Result side: random back-pressure, one long hold-off, checking.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
      if (!hold_done && sb.checked >= 40) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  // Random keys that mostly come from a reused pool, so hits are common.
  task random_word();
    logic [1:0] op;
    logic [31:0] a, b, c;
    int p;
    op = $urandom_range(3);
    if ($urandom_range(99) < 70) begin
      p = $urandom_range(47);
      a = key_pool[p][0];
      b = key_pool[p][1];
      c = key_pool[p][2];
    end else begin
      a = $urandom;
      b = ($urandom_range(3) == 0) ? 32'hffffffff : $urandom;
      c = ($urandom_range(3) == 0) ? 32'hffffffff : $urandom;
    end
    send_word(op, a, b, c);
  endtask

  // Main stimulus.
  initial begin
    logic [12:0] sizes [6];
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    steady = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    for (int i = 0; i < 48; i++) begin
      key_pool[i][0] = $urandom;
      key_pool[i][1] = (i % 4 == 0) ? 32'hffffffff : $urandom;
      key_pool[i][2] = (i % 5 == 0) ? 32'hffffffff : $urandom;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words at the default size: miss, insert, hits, duplicate insert.
    send_word(tkd_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_word(tkd_pkg::OP_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(tkd_pkg::OP_LOOKUP, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(tkd_pkg::OP_LOOKUP_INS, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(tkd_pkg::OP_INSERT, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(tkd_pkg::OP_LOOKUP_INS, 32'h0, 32'h0, 32'h0);
    send_word(tkd_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_word(tkd_pkg::OP_LOOKUP_INS, 32'h12345678, 32'hffffffff, 32'hffffffff);

    // One slot: fill it, then full insert and a lookup around a full table.
    write_size(13'd1);
    send_word(tkd_pkg::OP_INSERT, 32'h1, 32'h2, 32'h3);
    send_word(tkd_pkg::OP_INSERT, 32'h4, 32'h5, 32'h6);
    send_word(tkd_pkg::OP_LOOKUP_INS, 32'h4, 32'h5, 32'h6);
    send_word(tkd_pkg::OP_LOOKUP, 32'h4, 32'h5, 32'h6);
    send_word(2'd3, 32'h0, 32'h0, 32'h0);

    // Size zero acts as one; all ones acts as the full capacity.
    write_size(13'd0);
    send_word(tkd_pkg::OP_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_word(tkd_pkg::OP_INSERT, 32'h7, 32'h8, 32'h9);
    write_size(13'h1fff);
    send_word(tkd_pkg::OP_LOOKUP, 32'h4, 32'h5, 32'h6);
    send_word(tkd_pkg::OP_LOOKUP_INS, 32'h7, 32'h8, 32'h9);

    // Random phases over several sizes, one of them with no idling at all.
    sizes = '{13'd4096, 13'd37, 13'd3, 13'd200, 13'($urandom_range(1, 4096)), 13'd4096};
    for (int ph = 0; ph < 6; ph++) begin
      write_size(sizes[ph]);
      steady = (ph == 3);
      repeat (97) random_word();
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    // Drain and finish.
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("[triple_key_dedup_hash_table] OK");
    end else begin
      $display("[triple_key_dedup_hash_table] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tkd_pkg.sv
rtl/core/tkd_hash.sv
rtl/core/tkd_probe.sv
rtl/core/triple_key_dedup_hash_table.sv
tb/testbench.sv
